FILE: rtl/sgcf_pkg.sv
`default_nettype none

package sgcf_pkg;

    // Command queue between the front and back ends
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    // Frame sync bytes
    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'h55;

    // Register reset values and port widths
    localparam logic [7:0] FRAME_MODE_RESET = 8'd0;
    localparam logic [7:0] LIVE_LINES_RESET = 8'd8;
    localparam int         CFG_DATA_W       = 8;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_FRAME_MODE = 1'b0,
        REG_LIVE_LINES = 1'b1
    } reg_index_t;

    // Work handed from the front end to the serializer
    typedef enum logic [1:0] {
        CMD_HEADER      = 2'd0,
        CMD_SAMPLE      = 2'd1,
        CMD_SAMPLE_LAST = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  mode;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [9:0]  total;
        logic [15:0] value;
        logic [15:0] sum;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sgcf_if.sv
`default_nettype none

// Input word: frame start or one node sample
interface sgcf_item_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [7:0]         x_size;
    logic [7:0]         y_size;
    logic [9:0]         node_count;
    logic signed [15:0] node_value;

    modport source (output valid, func, x_size, y_size, node_count, node_value,
                    input ready);
    modport sink   (input valid, func, x_size, y_size, node_count, node_value,
                    output ready);
endinterface

// Output word: one byte of the serialized frame
interface sgcf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_first;
    logic       frame_last;

    modport source (output valid, out_byte, frame_first, frame_last, input ready);
    modport sink   (input valid, out_byte, frame_first, frame_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/sgcf_front.sv
`default_nettype none

module sgcf_front #(
    parameter int MAX_NODES = 512
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    sgcf_item_if.sink          items,
    input  wire logic [7:0]    frame_mode,
    input  wire logic [7:0]    live_lines,
    input  wire logic          q_full,
    output logic               push,
    output sgcf_pkg::cmd_t     push_cmd
);

    localparam logic [16:0] MAX_WIDE = 17'(MAX_NODES);

    logic        open_reg,  open_next;
    logic        crop_reg,  crop_next;
    logic [7:0]  height_reg, height_next;
    logic [7:0]  live_reg,  live_next;
    logic [9:0]  total_reg, total_next;
    logic [9:0]  index_reg, index_next;
    logic [7:0]  line_reg,  line_next;
    logic [15:0] sum_reg,   sum_next;

    logic        accept;
    logic [9:0]  cnt;
    logic [7:0]  xm1;
    logic [15:0] span;
    logic [16:0] need;
    logic [15:0] width_live;
    logic        crop;
    logic [9:0]  total;
    logic        keep;
    logic [7:0]  line_inc;
    logic [9:0]  index_inc;
    logic [15:0] sum_inc;

    assign items.ready = !q_full;
    assign accept      = items.valid && items.ready;

    // Clamp the promised count and decide on cropping
    always_comb
    begin
        if (17'(items.node_count) > MAX_WIDE)
        begin
            cnt = MAX_WIDE[9:0];
        end
        else
        begin
            cnt = items.node_count;
        end
        xm1        = items.x_size - 8'd1;
        span       = {8'd0, xm1} * {8'd0, items.y_size};
        need       = {1'b0, span} + {9'd0, live_lines};
        width_live = {8'd0, items.x_size} * {8'd0, live_lines};
        crop       = (items.x_size != 8'd0) && (live_lines != 8'd0) &&
                     (items.y_size > live_lines) && ({7'd0, cnt} >= need);
        total      = crop ? width_live[9:0] : cnt;
    end

    // Track the open frame and build the command for the serializer
    always_comb
    begin
        open_next   = open_reg;
        crop_next   = crop_reg;
        height_next = height_reg;
        live_next   = live_reg;
        total_next  = total_reg;
        index_next  = index_reg;
        line_next   = line_reg;
        sum_next    = sum_reg;
        push        = 1'b0;
        keep        = 1'b0;
        line_inc    = line_reg + 8'd1;
        index_inc   = index_reg + 10'd1;
        sum_inc     = sum_reg + {8'd0, items.node_value[7:0]}
                              + {8'd0, items.node_value[15:8]};

        push_cmd.kind   = sgcf_pkg::CMD_HEADER;
        push_cmd.mode   = frame_mode;
        push_cmd.width  = items.x_size;
        push_cmd.height = crop ? live_lines : items.y_size;
        push_cmd.total  = total;
        push_cmd.value  = items.node_value;
        push_cmd.sum    = sum_inc;

        if (accept && !items.func)
        begin
            open_next = 1'b0;
            if (cnt != 10'd0)
            begin
                open_next   = 1'b1;
                crop_next   = crop;
                height_next = items.y_size;
                live_next   = live_lines;
                total_next  = total;
                index_next  = 10'd0;
                line_next   = 8'd0;
                sum_next    = 16'd0;
                push        = 1'b1;
            end
        end
        else if (accept && open_reg)
        begin
            keep = !crop_reg || (line_reg < live_reg);
            // Advance the line position within the column
            if (crop_reg)
            begin
                line_next = (line_inc >= height_reg) ? 8'd0 : line_inc;
            end
            if (keep)
            begin
                push       = 1'b1;
                sum_next   = sum_inc;
                index_next = index_inc;
                if (index_inc >= total_reg)
                begin
                    push_cmd.kind = sgcf_pkg::CMD_SAMPLE_LAST;
                    open_next     = 1'b0;
                end
                else
                begin
                    push_cmd.kind = sgcf_pkg::CMD_SAMPLE;
                end
            end
        end
    end

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            crop_reg   <= 1'b0;
            height_reg <= 8'd0;
            live_reg   <= 8'd0;
            total_reg  <= 10'd0;
            index_reg  <= 10'd0;
            line_reg   <= 8'd0;
            sum_reg    <= 16'd0;
        end
        else
        begin
            open_reg   <= open_next;
            crop_reg   <= crop_next;
            height_reg <= height_next;
            live_reg   <= live_next;
            total_reg  <= total_next;
            index_reg  <= index_next;
            line_reg   <= line_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sgcf_queue.sv
`default_nettype none

module sgcf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sgcf_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output sgcf_pkg::cmd_t      head_cmd
);

    sgcf_pkg::cmd_t                   entry_reg [sgcf_pkg::QUEUE_DEPTH];
    logic [sgcf_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [sgcf_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [sgcf_pkg::QCNT_W-1:0]      count_reg,  count_next;

    assign full       = (count_reg == sgcf_pkg::QCNT_W'(sgcf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + sgcf_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + sgcf_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + sgcf_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - sgcf_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sgcf_back.sv
`default_nettype none

module sgcf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire sgcf_pkg::cmd_t q_cmd,
    output logic                q_pop,
    sgcf_byte_if.source         stream
);

    logic [2:0] step_reg,  step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg,  byte_next;
    logic       first_reg, first_next;
    logic       last_reg,  last_next;

    logic       load;
    logic [2:0] last_step;
    logic [7:0] sel_byte;

    assign stream.valid       = valid_reg;
    assign stream.out_byte    = byte_reg;
    assign stream.frame_first = first_reg;
    assign stream.frame_last  = last_reg;

    assign load  = q_valid && (!valid_reg || stream.ready);
    assign q_pop = load && (step_reg == last_step);

    // Pick the byte for the current step of the command
    always_comb
    begin
        last_step = 3'd1;
        sel_byte  = q_cmd.value[7:0];
        unique case (q_cmd.kind)
            sgcf_pkg::CMD_HEADER:
            begin
                last_step = 3'd6;
                case (step_reg)
                    3'd0:    sel_byte = sgcf_pkg::SYNC_A;
                    3'd1:    sel_byte = sgcf_pkg::SYNC_B;
                    3'd2:    sel_byte = q_cmd.mode;
                    3'd3:    sel_byte = q_cmd.width;
                    3'd4:    sel_byte = q_cmd.height;
                    3'd5:    sel_byte = q_cmd.total[7:0];
                    default: sel_byte = {6'd0, q_cmd.total[9:8]};
                endcase
            end
            sgcf_pkg::CMD_SAMPLE_LAST:
            begin
                last_step = 3'd3;
                case (step_reg)
                    3'd0:    sel_byte = q_cmd.value[7:0];
                    3'd1:    sel_byte = q_cmd.value[15:8];
                    3'd2:    sel_byte = q_cmd.sum[7:0];
                    default: sel_byte = q_cmd.sum[15:8];
                endcase
            end
            default:
            begin
                last_step = 3'd1;
                sel_byte  = (step_reg == 3'd0) ? q_cmd.value[7:0] : q_cmd.value[15:8];
            end
        endcase
    end

    // Load the output register one byte at a time
    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = sel_byte;
            first_next = (q_cmd.kind == sgcf_pkg::CMD_HEADER) && (step_reg == 3'd0);
            last_next  = (q_cmd.kind == sgcf_pkg::CMD_SAMPLE_LAST) &&
                         (step_reg == last_step);
            step_next  = (step_reg == last_step) ? 3'd0 : step_reg + 3'd1;
        end
        else if (stream.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        first_reg <= first_next;
        last_reg  <= last_next;
    end

endmodule

`default_nettype wire

FILE: rtl/sensor_grid_crop_framer.sv
// Sensor grid crop framer: takes a frame-start word (width, height, sample count) and then
// signed 16-bit node samples in column order, and emits the frame as one byte per output
// word: sync 0xAA 0x55, mode, width, height, count low/high, two bytes per kept sample, and
// a 16-bit byte sum low byte first. The front end accepts one input word per cycle whenever
// its four-entry command queue has room; the serializer behind it emits one byte per cycle
// while the output side is ready, through a registered output stage. Dropped samples
// (cropped lines, no open frame) and empty frame starts emit nothing. The user must see
// that registers are written through wr_en / wr_index / wr_data only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module sensor_grid_crop_framer #(
    parameter int MAX_NODES = 512
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    sgcf_item_if.sink                            items,
    sgcf_byte_if.source                          stream,
    input  wire logic                            wr_en,
    input  wire logic                            wr_index,
    input  wire logic [sgcf_pkg::CFG_DATA_W-1:0] wr_data
);

    logic [7:0]     frame_mode_reg;
    logic [7:0]     live_lines_reg;

    logic           q_full;
    logic           q_push;
    sgcf_pkg::cmd_t q_push_cmd;
    logic           q_pop;
    logic           q_valid;
    sgcf_pkg::cmd_t q_head;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg <= sgcf_pkg::FRAME_MODE_RESET;
            live_lines_reg <= sgcf_pkg::LIVE_LINES_RESET;
        end
        else if (wr_en)
        begin
            unique case (sgcf_pkg::reg_index_t'(wr_index))
                sgcf_pkg::REG_FRAME_MODE: frame_mode_reg <= wr_data;
                sgcf_pkg::REG_LIVE_LINES: live_lines_reg <= wr_data;
                default:                  frame_mode_reg <= frame_mode_reg;
            endcase
        end
    end

    sgcf_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .frame_mode (frame_mode_reg),
        .live_lines (live_lines_reg),
        .q_full     (q_full),
        .push       (q_push),
        .push_cmd   (q_push_cmd)
    );

    sgcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    sgcf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_head),
        .q_pop   (q_pop),
        .stream  (stream)
    );

endmodule

`default_nettype wire

FILE: dv/tb_sensor_grid_crop_framer.sv
`timescale 1ns / 1ps

module tb_sensor_grid_crop_framer;

    localparam int MAX_NODES      = 512;
    localparam int WORD_GOAL      = 250;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int LONG_FRAME     = 48;

    // One input word as the block sees it
    typedef struct packed {
        logic        func;
        logic [7:0]  x_size;
        logic [7:0]  y_size;
        logic [9:0]  node_count;
        logic [15:0] node_value;
    } grid_word_t;

    // One serialized byte with its frame marks
    typedef struct packed {
        logic [7:0] value;
        logic       first;
        logic       last;
    } frame_byte_t;

    // Tracks the frame state and the bytes the block still owes
    class frame_tracker;
        logic [7:0]  mode;
        logic [7:0]  live;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [9:0]  total;
        logic [9:0]  sent;
        logic [7:0]  line;
        logic [15:0] sum;
        bit          crop;
        bit          open;
        frame_byte_t due[$];
        int          mismatches;
        int          checked;
        int          closed;

        function new();
            mode       = sgcf_pkg::FRAME_MODE_RESET;
            live       = sgcf_pkg::LIVE_LINES_RESET;
            width      = '0;
            height     = '0;
            total      = '0;
            sent       = '0;
            line       = '0;
            sum        = '0;
            crop       = 1'b0;
            open       = 1'b0;
            mismatches = 0;
            checked    = 0;
            closed     = 0;
        endfunction

        function void set_reg(sgcf_pkg::reg_index_t idx, logic [7:0] data);
            if (idx == sgcf_pkg::REG_FRAME_MODE)
                mode = data;
            else
                live = data;
        endfunction

        function void push_byte(logic [7:0] value, bit first, bit last);
            frame_byte_t b;
            b.value = value;
            b.first = first;
            b.last  = last;
            due.push_back(b);
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Work out the bytes one accepted word causes
        function void take_word(grid_word_t w);
            int unsigned xs;
            int unsigned ys;
            int unsigned cnt;
            int unsigned lv;
            int unsigned kept_lines;
            logic [7:0]  head_h;
            logic [7:0]  lo;
            logic [7:0]  hi;
            bit          keep;

            // Frame start: abandon any open frame, latch size and crop
            if (w.func == 1'b0)
            begin
                open = 1'b0;
                xs   = w.x_size;
                ys   = w.y_size;
                cnt  = w.node_count;
                lv   = live;
                if (cnt > MAX_NODES)
                    cnt = MAX_NODES;
                if (cnt == 0)
                    return;
                crop   = (xs > 0) && (lv > 0) && (ys > lv) && (cnt >= (xs - 1) * ys + lv);
                width  = w.x_size;
                height = w.y_size;
                total  = crop ? 10'(xs * lv) : 10'(cnt);
                head_h = crop ? live : w.y_size;
                sent   = '0;
                line   = '0;
                sum    = '0;
                open   = 1'b1;
                push_byte(sgcf_pkg::SYNC_A, 1'b1, 1'b0);
                push_byte(sgcf_pkg::SYNC_B, 1'b0, 1'b0);
                push_byte(mode, 1'b0, 1'b0);
                push_byte(width, 1'b0, 1'b0);
                push_byte(head_h, 1'b0, 1'b0);
                push_byte(total[7:0], 1'b0, 1'b0);
                push_byte({6'd0, total[9:8]}, 1'b0, 1'b0);
                return;
            end

            // Drop samples outside a frame
            if (!open)
                return;

            // Drop lines past the kept count while cropping
            keep = 1'b1;
            if (crop)
            begin
                kept_lines = total / width;
                keep       = line < kept_lines;
                line       = line + 8'd1;
                if (line >= height)
                    line = 8'd0;
            end

            if (keep)
            begin
                lo = w.node_value[7:0];
                hi = w.node_value[15:8];
                push_byte(lo, 1'b0, 1'b0);
                push_byte(hi, 1'b0, 1'b0);
                sum  = sum + 16'(lo) + 16'(hi);
                sent = sent + 10'd1;
                if (sent >= total)
                begin
                    push_byte(sum[7:0], 1'b0, 1'b0);
                    push_byte(sum[15:8], 1'b0, 1'b1);
                    open = 1'b0;
                end
            end
        endfunction

        // Compare one accepted byte with the oldest owed byte
        function void match_byte(logic [7:0] value, logic first, logic last);
            frame_byte_t exp;
            if (due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected byte %02h first %0b last %0b",
                             $realtime, value, first, last);
                return;
            end
            exp = due.pop_front();
            checked++;
            if (exp.last === 1'b1)
                closed++;
            if (value !== exp.value || first !== exp.first || last !== exp.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: byte %0d got %02h/%0b/%0b, expected %02h/%0b/%0b",
                             $realtime, checked, value, first, last,
                             exp.value, exp.first, exp.last);
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            wr_en;
    logic                            wr_index;
    logic [sgcf_pkg::CFG_DATA_W-1:0] wr_data;

    sgcf_item_if items_ch();
    sgcf_byte_if bytes_ch();

    frame_tracker sb = new();

    bit send_steady;
    bit hold_request;
    int holds_done;
    int words_in;
    int settings;
    int idle_cycles;

    sensor_grid_crop_framer #(.MAX_NODES(MAX_NODES)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items_ch),
        .stream   (bytes_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Note accepted words, check accepted bytes, watch for a hang
    always @(posedge clk)
    begin
        grid_word_t w;
        bit         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (items_ch.valid && items_ch.ready)
            begin
                w.func       = items_ch.func;
                w.x_size     = items_ch.x_size;
                w.y_size     = items_ch.y_size;
                w.node_count = items_ch.node_count;
                w.node_value = items_ch.node_value;
                sb.take_word(w);
                words_in++;
                moved = 1'b1;
            end
            if (bytes_ch.valid && bytes_ch.ready)
            begin
                sb.match_byte(bytes_ch.out_byte, bytes_ch.frame_first, bytes_ch.frame_last);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d bytes still owed",
                         $realtime, idle_cycles, sb.pending());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Byte sink: random stalls, steady stretches, long hold-offs on request
    initial
    begin
        int gap;
        bit steady;
        bytes_ch.ready <= 1'b0;
        steady = 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 8);
            if (hold_request)
            begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
                holds_done++;
            end
            if (gap > 0)
            begin
                bytes_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            bytes_ch.ready <= 1'b1;
            do @(posedge clk); while (!(bytes_ch.valid && bytes_ch.ready));
        end
    end

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input grid_word_t w);
        int gap;
        if ($urandom_range(0, 19) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid      <= 1'b1;
        items_ch.func       <= w.func;
        items_ch.x_size     <= w.x_size;
        items_ch.y_size     <= w.y_size;
        items_ch.node_count <= w.node_count;
        items_ch.node_value <= w.node_value;
        do @(posedge clk); while (!(items_ch.valid && items_ch.ready));
    endtask

    task automatic send_start(input int x, input int y, input int cnt);
        grid_word_t w;
        w.func       = 1'b0;
        w.x_size     = 8'(x);
        w.y_size     = 8'(y);
        w.node_count = 10'(cnt);
        w.node_value = 16'($urandom);
        send_word(w);
    endtask

    task automatic send_sample(input logic [15:0] value);
        grid_word_t w;
        w.func       = 1'b1;
        w.x_size     = 8'($urandom);
        w.y_size     = 8'($urandom);
        w.node_count = 10'($urandom);
        w.node_value = value;
        send_word(w);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Stop offering, let owed bytes drain and the front end empty out
    task automatic quiesce();
        items_ch.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input sgcf_pkg::reg_index_t idx, input logic [7:0] data);
        sb.set_reg(idx, data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    // One frame: mostly well formed, sometimes cut short or followed by stray samples
    task automatic random_frame(inout int counted);
        int x;
        int y;
        int cnt;
        int eff;
        int lv;
        int need;
        int sent;
        bit crop;
        lv = sb.live;
        x  = $urandom_range(1, 6);
        y  = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: cnt = x * y;
            6:                cnt = $urandom_range(1, x * y);
            7:                cnt = 0;
            8:                cnt = $urandom_range(0, 1023);
            default:          cnt = x * y + $urandom_range(1, 3);
        endcase
        if ($urandom_range(0, 19) == 0)
        begin
            x   = 0;
            cnt = $urandom_range(1, 8);
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            x   = 2;
            y   = $urandom_range(20, 255);
            cnt = x * y;
        end
        eff  = (cnt > MAX_NODES) ? MAX_NODES : cnt;
        crop = (x > 0) && (lv > 0) && (y > lv) && (eff >= (x - 1) * y + lv);
        need = crop ? (x - 1) * y + lv : eff;
        case ($urandom_range(0, 9))
            0:       sent = (need > 0) ? $urandom_range(0, need - 1) : 0;
            1:       sent = need + $urandom_range(1, 3);
            default: sent = need;
        endcase
        // Cut long frames short; the header still carries the full count
        if (sent > LONG_FRAME)
            sent = $urandom_range(LONG_FRAME / 2, LONG_FRAME);
        send_start(x, y, cnt);
        for (int i = 0; i < sent; i++)
            send_sample(pick_value());
        counted += 1 + ((sent < need) ? sent : need);
    endtask

    initial
    begin
        int counted;
        int target;
        int phase;
        int lv;

        rst_n               <= 1'b0;
        wr_en               <= 1'b0;
        wr_index            <= sgcf_pkg::REG_FRAME_MODE;
        wr_data             <= '0;
        items_ch.valid      <= 1'b0;
        items_ch.func       <= 1'b0;
        items_ch.x_size     <= '0;
        items_ch.y_size     <= '0;
        items_ch.node_count <= '0;
        items_ch.node_value <= '0;
        send_steady  = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: plain frame with extreme samples, stray and empty starts
        send_start(2, 2, 4);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h1234);
        send_start(5, 5, 0);
        send_sample(16'h5A5A);

        // Top settings: clamped count, then abandon the frame
        quiesce();
        write_reg(sgcf_pkg::REG_FRAME_MODE, 8'hFF);
        write_reg(sgcf_pkg::REG_LIVE_LINES, 8'hFF);
        send_start(255, 255, 1023);
        send_sample(16'hA55A);
        send_sample(16'h0180);

        // One live line: keep line zero of each column
        quiesce();
        write_reg(sgcf_pkg::REG_FRAME_MODE, 8'h3C);
        write_reg(sgcf_pkg::REG_LIVE_LINES, 8'h01);
        send_start(3, 2, 5);
        for (int i = 0; i < 5; i++)
            send_sample(pick_value());

        // Zero live lines: no cropping at all
        quiesce();
        write_reg(sgcf_pkg::REG_FRAME_MODE, 8'h00);
        write_reg(sgcf_pkg::REG_LIVE_LINES, 8'h00);
        send_start(1, 3, 2);
        send_sample(16'hFF01);
        send_sample(16'h00FE);

        // Change live lines in the middle of a cropped frame
        quiesce();
        write_reg(sgcf_pkg::REG_LIVE_LINES, 8'h02);
        send_start(2, 4, 8);
        for (int i = 0; i < 3; i++)
            send_sample(pick_value());
        quiesce();
        write_reg(sgcf_pkg::REG_LIVE_LINES, 8'h03);
        for (int i = 0; i < 3; i++)
            send_sample(pick_value());

        // Random phases, each with fresh register values
        counted = 0;
        phase   = 0;
        while (counted < WORD_GOAL)
        begin
            quiesce();
            write_reg(sgcf_pkg::REG_FRAME_MODE, 8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
                0:       lv = 1;
                1:       lv = 255;
                2:       lv = 0;
                default: lv = $urandom_range(1, 10);
            endcase
            write_reg(sgcf_pkg::REG_LIVE_LINES, 8'(lv));
            if (phase == 1 || phase == 4)
                hold_request = 1'b1;
            target = counted + $urandom_range(30, 50);
            while (counted < target)
                random_frame(counted);
            phase++;
        end

        // Drain and report
        items_ch.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d input words, %0d bytes checked, %0d frames closed",
                 words_in, sb.checked, sb.closed);
        $display("over %0d register writes and %0d long output hold-offs, %0d mismatches",
                 settings, holds_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
